[rtl/core/bls_pkg.sv]
// shared types and constants of the battery level smoother
package bls_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LOW_MV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_MV         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_MAX_DROP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_DROP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD_S    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL       = 3'd5;

  // charge status codes
  localparam logic [2:0] ST_UNKNOWN      = 3'd0;
  localparam logic [2:0] ST_CHARGING     = 3'd1;
  localparam logic [2:0] ST_DISCHARGING  = 3'd2;
  localparam logic [2:0] ST_NOT_CHARGING = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  // full battery level
  localparam logic [6:0] LEVEL_FULL = 7'd100;

  // register reset values
  localparam logic [15:0] RST_CRITICAL_LOW_MV = 16'd3000;
  localparam logic [15:0] RST_DEAD_MV         = 16'd2800;
  localparam logic [6:0]  RST_NORMAL_MAX_DROP = 7'd2;
  localparam logic [6:0]  RST_CRITICAL_DROP   = 7'd6;
  localparam logic [15:0] RST_MIN_PERIOD_S    = 16'd55;
  localparam logic [6:0]  RST_LOW_LEVEL       = 7'd15;

  typedef struct packed {
    logic [15:0] critical_low_mv;
    logic [15:0] dead_mv;
    logic [6:0]  normal_max_drop;
    logic [6:0]  critical_drop;
    logic [15:0] min_period_s;
    logic [6:0]  low_level;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] raw_level;
    logic [2:0]        charge_status;
    logic [15:0]       cell_mv;
    logic [31:0]       uptime_s;
    logic              uptime_valid;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  level_out;
    logic        health;
    logic [2:0]  status_out;
    logic [15:0] monitor_mv;
    logic        monitor_changed;
  } out_word_t;

  typedef struct packed {
    logic        started;
    logic [6:0]  last_level;
    logic [31:0] last_time;
    logic        forcing_drop;
    logic [15:0] armed_mv;
  } state_t;

endpackage

[rtl/core/battery_level_smoother_unit.sv]
// top level of the battery level smoother: input register, step logic, result register
//
//   channel | signals                        | word
//   --------+--------------------------------+-------------
//   in      | in_valid, in_ready, in_word    | in_word_t
//   out     | out_valid, out_ready, out_word | out_word_t
//   cfg     | cfg_we, cfg_index, cfg_data    | 16-bit write
//
// a reading is captured in the input register and then moves on to the result
// register; the unit takes one reading per cycle while the result is not stalled.
// the smoothing state updates in the same edge that loads the result register.
// a stalled result holds the input register; in_ready drops only when both are full.
// synchronous active-high reset clears the state and valid flags; the data registers are not reset.
module battery_level_smoother_unit
  import bls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_word_t  in_q;
  logic      in_q_valid;
  state_t    state;
  state_t    state_next;
  out_word_t result;
  logic      advance;

  bls_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bls_step u_step (
    .cfg        (cfg),
    .item       (in_q),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  // handshake between the two register stages
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  // result register and smoothing state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      state     <= state_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  // an empty input register always takes a word
  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |-> in_ready)
    else $error("input register empty but not ready");

  // a word moving to the result register shows up as valid
  a_advance_out : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word lost");

  // reported level stays within 0..100
  a_level_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.level_out <= LEVEL_FULL)
    else $error("level out of range");

  // a full battery is never reported dead
  a_full_healthy : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.level_out == LEVEL_FULL |-> !out_word.health)
    else $error("full level reported dead");

  // unknown status is always corrected
  a_status_fixed : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.status_out != ST_UNKNOWN)
    else $error("unknown status passed through");

endmodule

[rtl/core/bls_config.sv]
// configuration register file of the battery level smoother
module bls_config
  import bls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.critical_low_mv <= RST_CRITICAL_LOW_MV;
      cfg.dead_mv         <= RST_DEAD_MV;
      cfg.normal_max_drop <= RST_NORMAL_MAX_DROP;
      cfg.critical_drop   <= RST_CRITICAL_DROP;
      cfg.min_period_s    <= RST_MIN_PERIOD_S;
      cfg.low_level       <= RST_LOW_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRITICAL_LOW_MV: cfg.critical_low_mv <= cfg_data;
        REG_DEAD_MV:         cfg.dead_mv         <= cfg_data;
        REG_NORMAL_MAX_DROP: cfg.normal_max_drop <= cfg_data[6:0];
        REG_CRITICAL_DROP:   cfg.critical_drop   <= cfg_data[6:0];
        REG_MIN_PERIOD_S:    cfg.min_period_s    <= cfg_data;
        REG_LOW_LEVEL:       cfg.low_level       <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/bls_step.sv]
// per-reading level smoothing, health, status and monitor logic
module bls_step
  import bls_pkg::*;
(
  input  cfg_t      cfg,
  input  in_word_t  item,
  input  state_t    state,
  output out_word_t result,
  output state_t    state_next
);

  // saturate a signed level to 0..100
  function automatic logic [6:0] clamp_level(input logic signed [10:0] v);
    logic signed [10:0] full_s;
    full_s = {4'b0, LEVEL_FULL};
    if (v < 0) return 7'd0;
    else if (v > full_s) return LEVEL_FULL;
    else return v[6:0];
  endfunction

  logic signed [10:0] full_s;
  logic signed [10:0] lvl;
  logic signed [10:0] ll;
  logic signed [10:0] soc;
  logic signed [10:0] dec;
  logic signed [10:0] nmd_s;
  logic signed [10:0] cd_s;
  logic [31:0]        now;
  logic [31:0]        lt;
  logic [31:0]        elapsed;
  logic               too_soon;
  logic               discharging;
  logic               update_time;
  logic               forcing;
  logic [6:0]         level;
  logic [2:0]         st;
  logic [15:0]        mon;

  always_comb begin
    full_s = {4'b0, LEVEL_FULL};
    nmd_s  = {4'b0, cfg.normal_max_drop};
    cd_s   = {4'b0, cfg.critical_drop};
    now    = item.uptime_valid ? item.uptime_s : state.last_time;
    lvl    = {{2{item.raw_level[8]}}, item.raw_level};
    ll     = {4'b0, state.last_level};
    lt     = state.last_time;

    // first reading seeds the level (capped below full) and the time
    if (!state.started) begin
      if (lvl >= full_s) lvl = full_s - 11'sd1;
      ll = {4'b0, clamp_level(lvl)};
      lt = now;
    end

    elapsed  = now - lt;
    too_soon = (now > lt) && (elapsed <= {16'b0, cfg.min_period_s});

    // starting level before rate limits
    if (item.charge_status == ST_FULL) soc = full_s;
    else if (lvl >= full_s && ll < full_s) soc = full_s - 11'sd1;
    else soc = lvl;

    discharging = (item.charge_status == ST_UNKNOWN) ||
                  (item.charge_status == ST_DISCHARGING) ||
                  (item.charge_status == ST_NOT_CHARGING);
    dec         = ll - soc;
    update_time = 1'b1;
    forcing     = state.forcing_drop;

    // rate limiting
    if (discharging) begin
      if (item.cell_mv >= cfg.critical_low_mv) begin
        forcing = 1'b0;
        if (dec < 0 || too_soon) begin
          soc         = ll;
          update_time = 1'b0;
        end else begin
          soc = (dec > nmd_s) ? (ll - nmd_s) : (ll - dec);
        end
      end else if (item.cell_mv < cfg.dead_mv) begin
        soc = '0;
      end else if (state.forcing_drop && too_soon) begin
        soc         = ll;
        update_time = 1'b0;
      end else begin
        soc     = (ll <= cd_s) ? 11'sd0 : (ll - cd_s);
        forcing = 1'b1;
      end
    end else begin
      forcing = 1'b0;
      if (soc > ll) soc = ll + 11'sd1;
    end

    level = clamp_level(soc);

    // corrected status
    if (item.charge_status == ST_UNKNOWN) st = ST_DISCHARGING;
    else if (item.charge_status == ST_FULL && level < LEVEL_FULL) st = ST_CHARGING;
    else st = item.charge_status;

    // monitor threshold to arm
    mon = '0;
    if (st != ST_CHARGING && st != ST_FULL && level != 7'd0) begin
      if (item.cell_mv > cfg.critical_low_mv) mon = cfg.critical_low_mv;
      else if (item.cell_mv > cfg.dead_mv) mon = cfg.dead_mv;
    end

    result.level_out       = level;
    result.health          = (level >= LEVEL_FULL) ? 1'b0 : (level < cfg.low_level);
    result.status_out      = st;
    result.monitor_mv      = mon;
    result.monitor_changed = (mon != state.armed_mv);

    state_next.started      = 1'b1;
    state_next.last_level   = level;
    state_next.last_time    = update_time ? now : lt;
    state_next.forcing_drop = forcing;
    state_next.armed_mv     = mon;
  end

endmodule

[sim/tb_battery_level_smoother_unit.sv]
// testbench of the battery level smoother: directed and random readings checked against a predictor
module tb_battery_level_smoother_unit;
  import bls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_LEVEL  = LEVEL_FULL;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SHOWN_LIMIT = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // smoother state and register copy of the predictor
  cfg_t        live_cfg;
  bit          smooth_started;
  int          smooth_level;
  logic [31:0] smooth_time;
  bit          smooth_forcing;
  logic [15:0] smooth_armed;

  out_word_t   expected_reports[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic [31:0] stim_clock = 32'd10000;

  battery_level_smoother_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    mismatch_count++;
    // keep the log short on a badly broken block
    if (mismatch_count <= SHOWN_LIMIT)
      $display("mismatch %s: expected %0d got %0d", what, want, got);
  endtask

  function automatic int clamp_level(int v);
    if (v < 0) return 0;
    if (v > FULL_LEVEL) return FULL_LEVEL;
    return v;
  endfunction

  // a drop is refused while time has moved on by no more than a full period
  function automatic bit too_soon(logic [31:0] now);
    return now > smooth_time && (now - smooth_time) <= {16'd0, live_cfg.min_period_s};
  endfunction

  function automatic void reset_predictor();
    live_cfg.critical_low_mv = RST_CRITICAL_LOW_MV;
    live_cfg.dead_mv         = RST_DEAD_MV;
    live_cfg.normal_max_drop = RST_NORMAL_MAX_DROP;
    live_cfg.critical_drop   = RST_CRITICAL_DROP;
    live_cfg.min_period_s    = RST_MIN_PERIOD_S;
    live_cfg.low_level       = RST_LOW_LEVEL;
    smooth_started = 1'b0;
    smooth_level   = 0;
    smooth_time    = '0;
    smooth_forcing = 1'b0;
    smooth_armed   = '0;
  endfunction

  // advance the smoother by one reading and return its report
  function automatic out_word_t predict_report(in_word_t w);
    int          lvl;
    int          soc;
    int          drop;
    logic [31:0] now;
    logic [2:0]  st;
    logic [15:0] mon;
    bit          stamp;
    out_word_t   rep;
    lvl   = $signed(w.raw_level);
    now   = w.uptime_valid ? w.uptime_s : smooth_time;
    mon   = '0;
    stamp = 1'b1;

    // first reading seeds the level, capped below full
    if (!smooth_started) begin
      if (lvl >= FULL_LEVEL) lvl = FULL_LEVEL - 1;
      smooth_level   = clamp_level(lvl);
      smooth_time    = now;
      smooth_started = 1'b1;
    end

    if (w.charge_status == ST_FULL)
      soc = FULL_LEVEL;
    else if (lvl >= FULL_LEVEL && smooth_level < FULL_LEVEL)
      soc = FULL_LEVEL - 1;
    else
      soc = lvl;

    // discharge: rate limit, forced drop or dead; otherwise rise by one at most
    if (w.charge_status inside {ST_UNKNOWN, ST_DISCHARGING, ST_NOT_CHARGING}) begin
      if (w.cell_mv >= live_cfg.critical_low_mv) begin
        drop = smooth_level - soc;
        smooth_forcing = 1'b0;
        if (drop < 0 || too_soon(now)) begin
          soc   = smooth_level;
          stamp = 1'b0;
        end else begin
          if (drop > int'(live_cfg.normal_max_drop)) drop = int'(live_cfg.normal_max_drop);
          soc = smooth_level - drop;
        end
      end else if (w.cell_mv < live_cfg.dead_mv) begin
        soc = 0;
      end else if (smooth_forcing && too_soon(now)) begin
        soc   = smooth_level;
        stamp = 1'b0;
      end else begin
        if (smooth_level <= int'(live_cfg.critical_drop))
          soc = 0;
        else
          soc = smooth_level - int'(live_cfg.critical_drop);
        smooth_forcing = 1'b1;
      end
    end else begin
      smooth_forcing = 1'b0;
      if (soc > smooth_level) soc = smooth_level + 1;
    end

    if (stamp) smooth_time = now;
    soc = clamp_level(soc);
    smooth_level = soc;

    // status correction and monitor threshold
    st = w.charge_status;
    if (st == ST_UNKNOWN)
      st = ST_DISCHARGING;
    else if (st == ST_FULL && soc < FULL_LEVEL)
      st = ST_CHARGING;
    if (st != ST_CHARGING && st != ST_FULL && soc > 0) begin
      if (w.cell_mv > live_cfg.critical_low_mv)
        mon = live_cfg.critical_low_mv;
      else if (w.cell_mv > live_cfg.dead_mv)
        mon = live_cfg.dead_mv;
    end

    rep.level_out       = soc[6:0];
    rep.health          = (soc < FULL_LEVEL) && (soc < int'(live_cfg.low_level));
    rep.status_out      = st;
    rep.monitor_mv      = mon;
    rep.monitor_changed = (mon != smooth_armed);
    smooth_armed = mon;
    return rep;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // compare each delivered word with the oldest expected report
  always @(posedge clk) begin : check_reports
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected word", 0, out_word);
      end else begin
        want = expected_reports.pop_front();
        if (out_word.level_out != want.level_out)
          report_mismatch("level_out", want.level_out, out_word.level_out);
        if (out_word.health != want.health)
          report_mismatch("health", want.health, out_word.health);
        if (out_word.status_out != want.status_out)
          report_mismatch("status_out", want.status_out, out_word.status_out);
        if (out_word.monitor_mv != want.monitor_mv)
          report_mismatch("monitor_mv", want.monitor_mv, out_word.monitor_mv);
        if (out_word.monitor_changed != want.monitor_changed)
          report_mismatch("monitor_changed", want.monitor_changed, out_word.monitor_changed);
      end
    end
  end

  // offer one reading, with random idle cycles ahead of it
  task automatic send_reading(in_word_t w);
    logic [63:0] noise;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      noise    = {$urandom, $urandom};
      in_valid <= 1'b0;
      in_word  <= noise[$bits(in_word_t)-1:0];
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    expected_reports.push_back(predict_report(w));
  endtask

  // stop sending and let every report come back
  task automatic wait_for_reports();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (expected_reports.size() != 0) begin
      report_mismatch("reports never delivered", 0, expected_reports.size());
      expected_reports.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CRITICAL_LOW_MV: live_cfg.critical_low_mv = data;
      REG_DEAD_MV:         live_cfg.dead_mv         = data;
      REG_NORMAL_MAX_DROP: live_cfg.normal_max_drop = data[6:0];
      REG_CRITICAL_DROP:   live_cfg.critical_drop   = data[6:0];
      REG_MIN_PERIOD_S:    live_cfg.min_period_s    = data;
      REG_LOW_LEVEL:       live_cfg.low_level       = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] crit_mv, logic [15:0] dead_level_mv,
                                logic [15:0] max_drop, logic [15:0] forced_drop,
                                logic [15:0] period_s, logic [15:0] low);
    wait_for_reports();
    write_setting(REG_CRITICAL_LOW_MV, crit_mv);
    write_setting(REG_DEAD_MV, dead_level_mv);
    write_setting(REG_NORMAL_MAX_DROP, max_drop);
    write_setting(REG_CRITICAL_DROP, forced_drop);
    write_setting(REG_MIN_PERIOD_S, period_s);
    write_setting(REG_LOW_LEVEL, low);
  endtask

  function automatic in_word_t reading(int raw, logic [2:0] status, logic [15:0] cell_mv,
                                       logic [31:0] uptime, logic uptime_ok);
    in_word_t w;
    w.raw_level     = raw[8:0];
    w.charge_status = status;
    w.cell_mv       = cell_mv;
    w.uptime_s      = uptime;
    w.uptime_valid  = uptime_ok;
    return w;
  endfunction

  // mostly plausible polling with level drift, thresholds and period steps; some noise
  function automatic in_word_t random_reading();
    in_word_t    w;
    int          pick;
    logic [31:0] period;
    logic [63:0] noise;
    if ($urandom_range(0, 99) < 12) begin
      noise = {$urandom, $urandom};
      w     = noise[$bits(in_word_t)-1:0];
      return w;
    end
    period = {16'd0, live_cfg.min_period_s};

    if ($urandom_range(0, 9) == 0)
      w.raw_level = 9'($urandom_range(0, 511));
    else
      w.raw_level = 9'(smooth_level + int'($urandom_range(0, 11)) - 8);

    pick = $urandom_range(0, 19);
    if (pick < 4)        w.charge_status = ST_UNKNOWN;
    else if (pick < 12)  w.charge_status = ST_DISCHARGING;
    else if (pick < 14)  w.charge_status = ST_NOT_CHARGING;
    else if (pick < 17)  w.charge_status = ST_CHARGING;
    else if (pick < 19)  w.charge_status = ST_FULL;
    else                 w.charge_status = 3'($urandom_range(5, 7));

    case ($urandom_range(0, 5))
      0: w.cell_mv = 16'(live_cfg.critical_low_mv + $urandom_range(0, 4) - 2);
      1: w.cell_mv = 16'(live_cfg.dead_mv + $urandom_range(0, 4) - 2);
      2: w.cell_mv = 16'($urandom_range(65535, live_cfg.critical_low_mv));
      3: w.cell_mv = 16'($urandom_range(live_cfg.critical_low_mv, live_cfg.dead_mv));
      4: w.cell_mv = 16'($urandom_range(live_cfg.dead_mv, 0));
      default: w.cell_mv = 16'($urandom);
    endcase

    // time mostly moves on by up to two periods plus two seconds, now and then backward
    if ($urandom_range(0, 99) < 5)
      stim_clock = stim_clock - $urandom_range(0, 100);
    else
      stim_clock = stim_clock + $urandom_range(0, 2 * period + 2);
    w.uptime_s     = stim_clock;
    w.uptime_valid = ($urandom_range(0, 9) != 0);
    return w;
  endfunction

  task automatic send_random_readings(int count);
    repeat (count) send_reading(random_reading());
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // first reading, period edges, forced drop, dead cell, odd status codes
  task automatic test_directed_cases();
    set_idling(0, 0);
    send_reading(reading(255, ST_DISCHARGING, 16'd4000, 32'd1000, 1'b1));
    send_reading(reading(100, ST_CHARGING, 16'd4200, 32'd1010, 1'b1));
    send_reading(reading(50, ST_FULL, 16'd4200, 32'd1020, 1'b1));
    send_reading(reading(97, ST_UNKNOWN, 16'd3000, 32'd1100, 1'b1));
    send_reading(reading(90, ST_DISCHARGING, 16'd3500, 32'd1130, 1'b1));
    send_reading(reading(90, ST_DISCHARGING, 16'd3500, 32'd1155, 1'b1));
    send_reading(reading(90, ST_DISCHARGING, 16'd3500, 32'd1156, 1'b1));
    send_reading(reading(96, ST_NOT_CHARGING, 16'd2999, 32'd1157, 1'b1));
    send_reading(reading(96, ST_NOT_CHARGING, 16'd2999, 32'd1180, 1'b1));
    send_reading(reading(96, ST_DISCHARGING, 16'd2900, 32'hFFFF_FFFF, 1'b0));
    send_reading(reading(96, ST_DISCHARGING, 16'd2800, 32'd5, 1'b1));
    send_reading(reading(40, ST_DISCHARGING, 16'd2799, 32'd200, 1'b1));
    send_reading(reading(-256, ST_CHARGING, 16'd0, 32'd300, 1'b1));
    send_reading(reading(255, 3'd5, 16'd3100, 32'd400, 1'b1));
    send_reading(reading(20, 3'd6, 16'd2900, 32'd500, 1'b1));
    send_reading(reading(0, 3'd7, 16'd3100, 32'd600, 1'b1));
    send_reading(reading(3, ST_CHARGING, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    send_reading(reading(0, ST_DISCHARGING, 16'hFFFF, 32'd0, 1'b1));
    send_reading(reading(-1, ST_FULL, 16'd3001, 32'd100, 1'b1));
    send_reading(reading(101, ST_UNKNOWN, 16'd2801, 32'd200, 1'b1));
    send_reading(reading(0, ST_DISCHARGING, 16'd0, 32'd300, 1'b0));
    send_reading(reading(-255, ST_NOT_CHARGING, 16'd3001, 32'h8000_0000, 1'b1));
  endtask

  task automatic test_steady_flow();
    apply_settings(RST_CRITICAL_LOW_MV, RST_DEAD_MV, RST_NORMAL_MAX_DROP,
                   RST_CRITICAL_DROP, RST_MIN_PERIOD_S, RST_LOW_LEVEL);
    set_idling(0, 0);
    send_random_readings(250);
  endtask

  task automatic test_sparse_sender();
    apply_settings(16'd3400, 16'd3100, 16'd5, 16'd10, 16'd30, 16'd20);
    set_idling(81, 0);
    send_random_readings(250);
  endtask

  // all registers at zero
  task automatic test_slow_receiver();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    set_idling(0, 81);
    send_random_readings(200);
  endtask

  // all register bits set
  task automatic test_both_idle();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_idling(36, 36);
    send_random_readings(200);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      apply_settings(16'($urandom_range(2000, 4200)), 16'($urandom_range(1500, 3500)),
                     16'($urandom_range(0, 12)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 120)), 16'($urandom_range(0, 100)));
      set_idling(0, 0);
      send_random_readings(30);
      set_idling(36, 36);
      send_random_readings(40);
    end
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_steady_flow();
    test_sparse_sender();
    test_slow_receiver();
    test_both_idle();
    test_random_settings();
    wait_for_reports();

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
